// ----- hw/rtl/multi_stepper_pulse_scheduler_unit_macros.svh -----
// Assertion macros shared by the scheduler checker.
`ifndef MULTI_STEPPER_PULSE_SCHEDULER_UNIT_MACROS_SVH
`define MULTI_STEPPER_PULSE_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, masked while in reset
`define MSPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, masked while in reset
`define MSPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication that also watches the reset itself
`define MSPS_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ----- hw/rtl/msps_pkg.sv -----
// Shared types and constants for the multi-stepper pulse scheduler.
package msps_pkg;

    localparam int NumMotorsDef = 8;
    localparam int MaskW        = 8;
    localparam int DataW        = 32;
    localparam int TickW        = 16;
    localparam int PwW          = 8;
    localparam int TallyW       = 8;
    localparam int IdxW         = 8;
    localparam int CfgIdxW      = 2;
    localparam int InDataW      = 120;
    localparam int OutDataW     = 24;

    localparam logic [TickW-1:0] TickLengthRst = 16'd100;
    localparam logic [DataW-1:0] MinPeriodRst  = 32'd100;
    localparam logic [DataW-1:0] MaxPeriodRst  = 32'd100000;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_FLAGS = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_INDEX   = 2'd1,
        ST_ZERO_PERIOD = 2'd2
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TICK_LENGTH      = 2'd0,
        CFG_MIN_PERIOD       = 2'd1,
        CFG_MAX_PERIOD       = 2'd2,
        CFG_STEPS_PER_UPDATE = 2'd3
    } t_cfg_idx;

    // Request to the shared adder
    typedef struct packed {
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic             sub;
    } t_alu_req;

    // Compare results for the motor being visited
    typedef struct packed {
        logic due;
        logic ge_min;
        logic ge_max;
    } t_cmp;

endpackage

// ----- hw/rtl/msps_alu.sv -----
// Shared adder and compare unit used for every motor in turn.
module msps_alu import msps_pkg::*; (
    input  t_alu_req         i_req,
    input  logic [DataW-1:0] i_countdown,
    input  logic [TickW-1:0] i_tick,
    input  logic [DataW-1:0] i_period,
    input  logic [DataW-1:0] i_min,
    input  logic [DataW-1:0] i_max,
    output logic [DataW-1:0] o_sum,
    output t_cmp             o_cmp
);

    // One 32-bit add/subtract, wrapping
    always_comb begin
        if (i_req.sub) begin
            o_sum = i_req.a - i_req.b;
        end else begin
            o_sum = i_req.a + i_req.b;
        end
    end

    // Step due test and ramp limit tests
    always_comb begin
        o_cmp.due    = (i_countdown <= {{(DataW-TickW){1'b0}}, i_tick});
        o_cmp.ge_min = (i_period >= i_min);
        o_cmp.ge_max = (i_period >= i_max);
    end

endmodule

// ----- hw/rtl/multi_stepper_pulse_scheduler_unit.sv -----
// Top level of the multi-stepper step pulse scheduler with shared ramp.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+--------------------------------------
//  s_axis   | in        | tvalid/tready          | tuser op, tdata motion and flag fields
//  m_axis   | out       | tvalid/tready          | tdata step mask, error mask, status
//  i_cfg    | in        | i_cfg_we (no wait)     | i_cfg_index, i_cfg_data
//
// Load, flags and unused op beats go from accept to the finish state and the result.
// A tick walks the motors in order through one shared adder: an idle or counting
// motor takes only the evaluate state, a step adds the reload state, and a step
// with a ramp subtract passes update before reload. One beat is in work at a time.
// Synchronous active-low reset clears all motor state and loads config defaults.
// A result waits in the output register; the next beat is taken meanwhile.
module multi_stepper_pulse_scheduler_unit import msps_pkg::*; #(
    parameter int NUM_MOTORS = NumMotorsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config write port
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [DataW-1:0]    i_cfg_data,
    // input beats
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [1:0] op
    input  logic [1:0]          s_axis_tuser,
    // [7:0] motor_index, [39:8] step_count, [71:40] step_period,
    // [103:72] accel_amount, [111:104] pulse_width, [112] enable_in,
    // [113] stop_in, [114] error_in, [119:115] zero
    input  logic [InDataW-1:0]  s_axis_tdata,
    // result beats
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [7:0] step_mask, [15:8] error_mask, [17:16] status, [23:18] zero
    output logic [OutDataW-1:0] m_axis_tdata
);

    localparam int MotW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam logic [MotW-1:0] LastMotor = MotW'(NUM_MOTORS - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVAL   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_RELOAD = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    // Control and config
    t_state                 r_state;
    logic [MotW-1:0]        r_motor;
    logic [MaskW-1:0]       r_step_mask;
    t_status                r_status;
    logic [TallyW-1:0]      r_tally;
    logic [TickW-1:0]       r_tick_length;
    logic [DataW-1:0]       r_min_period;
    logic [DataW-1:0]       r_max_period;
    logic [TallyW-1:0]      r_steps_per_update;
    logic                   r_out_valid;
    logic [OutDataW-1:0]    r_out_data;

    // Per-motor state
    logic [DataW-1:0]       r_steps_left [NUM_MOTORS];
    logic [DataW-1:0]       r_countdown  [NUM_MOTORS];
    logic [DataW-1:0]       r_period     [NUM_MOTORS];
    logic [DataW-1:0]       r_accel      [NUM_MOTORS];
    logic [PwW-1:0]         r_pulse      [NUM_MOTORS];
    logic [NUM_MOTORS-1:0]  r_enabled;
    logic [NUM_MOTORS-1:0]  r_stopped;
    logic [NUM_MOTORS-1:0]  r_faulted;

    // Input field views
    t_op                    w_op;
    logic [IdxW-1:0]        w_idx;
    logic [DataW-1:0]       w_count;
    logic [DataW-1:0]       w_per;
    logic [DataW-1:0]       w_acc;
    logic [PwW-1:0]         w_pw;
    logic                   w_en_in;
    logic                   w_stop_in;
    logic                   w_err_in;
    logic [MotW-1:0]        w_slot;
    logic                   w_bad_idx;

    logic                   w_in_acc;
    logic                   w_out_free;
    logic                   w_last;
    logic                   w_active;
    logic [TallyW-1:0]      n_tally;
    logic                   w_tally_hit;
    logic [DataW-1:0]       w_reload_off;
    logic [MaskW-1:0]       w_err_mask;
    logic [MaskW-1:0]       n_step_mask;
    t_alu_req               w_req;
    logic [DataW-1:0]       w_sum;
    t_cmp                   w_cmp;

    assign w_op      = t_op'(s_axis_tuser);
    assign w_idx     = s_axis_tdata[7:0];
    assign w_count   = s_axis_tdata[39:8];
    assign w_per     = s_axis_tdata[71:40];
    assign w_acc     = s_axis_tdata[103:72];
    assign w_pw      = s_axis_tdata[111:104];
    assign w_en_in   = s_axis_tdata[112];
    assign w_stop_in = s_axis_tdata[113];
    assign w_err_in  = s_axis_tdata[114];
    assign w_slot    = w_idx[MotW-1:0];
    assign w_bad_idx = (w_idx >= IdxW'(NUM_MOTORS));

    // Handshakes
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = ~r_out_valid | m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Motor being visited
    assign w_last      = (r_motor == LastMotor);
    assign w_active    = r_enabled[r_motor] & ~r_stopped[r_motor]
                         & (r_steps_left[r_motor] != '0);
    assign n_tally     = r_tally + TallyW'(1);
    assign w_tally_hit = (n_tally == r_steps_per_update);
    assign n_step_mask = r_step_mask | (MaskW'(1) << r_motor);
    assign w_reload_off = {{(DataW-TickW){1'b0}}, r_tick_length}
                          - {{(DataW-PwW){1'b0}}, r_pulse[r_motor]};

    // Error flags onto the fixed-width mask
    for (genvar g = 0; g < MaskW; g++) begin : g_err
        if (g < NUM_MOTORS) begin : g_on
            assign w_err_mask[g] = r_faulted[g];
        end else begin : g_off
            assign w_err_mask[g] = 1'b0;
        end
    end

    // Operand selection for the shared adder
    always_comb begin
        unique case (r_state)
            S_UPDATE: begin
                w_req.a   = r_period[r_motor];
                w_req.b   = r_accel[r_motor];
                w_req.sub = 1'b1;
            end
            S_RELOAD: begin
                w_req.a   = r_period[r_motor];
                w_req.b   = w_reload_off;
                w_req.sub = 1'b0;
            end
            default: begin
                w_req.a   = r_countdown[r_motor];
                w_req.b   = {{(DataW-TickW){1'b0}}, r_tick_length};
                w_req.sub = 1'b1;
            end
        endcase
    end

    msps_alu u_alu (
        .i_req       (w_req),
        .i_countdown (r_countdown[r_motor]),
        .i_tick      (r_tick_length),
        .i_period    (r_period[r_motor]),
        .i_min       (r_min_period),
        .i_max       (r_max_period),
        .o_sum       (w_sum),
        .o_cmp       (w_cmp)
    );

    // Sequencer, motor state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_motor            <= '0;
            r_step_mask        <= '0;
            r_status           <= ST_OK;
            r_tally            <= '0;
            r_tick_length      <= TickLengthRst;
            r_min_period       <= MinPeriodRst;
            r_max_period       <= MaxPeriodRst;
            r_steps_per_update <= '0;
            r_out_valid        <= 1'b0;
            r_enabled          <= '0;
            r_stopped          <= '0;
            r_faulted          <= '0;
            for (int i = 0; i < NUM_MOTORS; i++) begin
                r_steps_left[i] <= '0;
                r_countdown[i]  <= '0;
                r_period[i]     <= '0;
                r_accel[i]      <= '0;
                r_pulse[i]      <= '0;
            end
        end else begin
            // config writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TICK_LENGTH:      r_tick_length      <= i_cfg_data[TickW-1:0];
                    CFG_MIN_PERIOD:       r_min_period       <= i_cfg_data;
                    CFG_MAX_PERIOD:       r_max_period       <= i_cfg_data;
                    CFG_STEPS_PER_UPDATE: r_steps_per_update <= i_cfg_data[TallyW-1:0];
                endcase
            end

            // result beat taken; a finishing beat refills the register instead
            if (m_axis_tvalid && m_axis_tready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_step_mask <= '0;
                        r_status    <= ST_OK;
                        r_motor     <= '0;
                        unique case (w_op)
                            OP_TICK: begin
                                r_state <= S_EVAL;
                            end
                            OP_LOAD: begin
                                r_state <= S_FINISH;
                                if (w_bad_idx) begin
                                    r_status <= ST_BAD_INDEX;
                                end else begin
                                    r_steps_left[w_slot] <= w_count;
                                    r_countdown[w_slot]  <= '0;
                                    if (w_per == '0) begin
                                        r_status <= ST_ZERO_PERIOD;
                                    end else begin
                                        r_period[w_slot] <= w_per;
                                        r_accel[w_slot]  <= w_acc;
                                        r_pulse[w_slot]  <= w_pw;
                                    end
                                end
                            end
                            OP_FLAGS: begin
                                r_state <= S_FINISH;
                                if (w_bad_idx) begin
                                    r_status <= ST_BAD_INDEX;
                                end else begin
                                    r_enabled[w_slot] <= w_en_in;
                                    r_stopped[w_slot] <= w_stop_in;
                                    r_faulted[w_slot] <= w_err_in;
                                end
                            end
                            OP_NONE: begin
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end

                // decide step, clamp the ramp, or count down
                S_EVAL: begin
                    if (w_active && w_cmp.due) begin
                        r_step_mask <= n_step_mask;
                        if (w_tally_hit) begin
                            r_tally <= '0;
                            if (!w_cmp.ge_min) begin
                                r_period[r_motor] <= r_min_period;
                                r_state           <= S_RELOAD;
                            end else if (w_cmp.ge_max) begin
                                r_period[r_motor]  <= r_max_period;
                                r_faulted[r_motor] <= 1'b1;
                                r_state            <= S_RELOAD;
                            end else begin
                                r_state <= S_UPDATE;
                            end
                        end else begin
                            r_tally <= n_tally;
                            r_state <= S_RELOAD;
                        end
                    end else begin
                        if (w_active) begin
                            r_countdown[r_motor] <= w_sum;
                        end
                        if (w_last) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_motor <= r_motor + MotW'(1);
                        end
                    end
                end

                // period minus acceleration
                S_UPDATE: begin
                    r_period[r_motor] <= w_sum;
                    r_state           <= S_RELOAD;
                end

                // reload countdown and use up one step
                S_RELOAD: begin
                    r_countdown[r_motor]  <= w_sum;
                    r_steps_left[r_motor] <= r_steps_left[r_motor] - DataW'(1);
                    if (w_last) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_motor <= r_motor + MotW'(1);
                        r_state <= S_EVAL;
                    end
                end

                // hand the result to the output register
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {{(OutDataW-2*MaskW-2){1'b0}}, r_status,
                                        w_err_mask, r_step_mask};
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/msps_checker.sv -----
// Port-level checker for the scheduler, bound to the top level.
`include "multi_stepper_pulse_scheduler_unit_macros.svh"

module msps_checker import msps_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata
);

    // a stalled result beat stays offered
    `MSPS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // status is always one of the defined codes
    `MSPS_ASSERT_IMP(a_status_code, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[17:16] == ST_OK) || (m_axis_tdata[17:16] == ST_BAD_INDEX) || (m_axis_tdata[17:16] == ST_ZERO_PERIOD))

    // a taken beat leaves the block busy in the following cycle
    `MSPS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // no result is offered straight after reset
    `MSPS_ASSERT_RST(a_quiet_after_reset, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind multi_stepper_pulse_scheduler_unit msps_checker u_msps_checker (.*);
